/* hw/rtl/wma_pkg.sv */
// Shared types and constants for the warmup moving average core.
// No dependencies; imported by every module of the block.
package wma_pkg;

  // Sample and average field width (percent times 100)
  localparam int SAMPLE_W = 14;
  // Stream data width: sample padded to whole bytes
  localparam int TDATA_W = 16;
  // Default window depth
  localparam int WINDOW_DEPTH_DEF = 32;

endpackage

/* hw/rtl/wma_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on wma_pkg for the default width and depth.
module wma_ram
  import wma_pkg::*;
#(
  parameter int WIDTH = SAMPLE_W,
  parameter int DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/wma_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on wma_pkg; used by the top level to divide sum by count.
module wma_div
  import wma_pkg::*;
#(
  parameter int NUM_W = 19,
  parameter int DEN_W = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  quo;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den;
  logic [STEP_W-1:0] steps;
  logic [DEN_W:0]    trial;
  logic              fits;

  // shift in next dividend bit and compare against divisor
  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      // done pulses for one cycle after the last quotient bit
      done <= busy && !start && (steps == STEP_W'(1));
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(NUM_W);
        quo   <= dividend;
        den   <= divisor;
        rem   <= '0;
      end else if (busy) begin
        if (fits) begin
          rem <= DEN_W'(trial - {1'b0, den});
        end else begin
          rem <= trial[DEN_W-1:0];
        end
        quo   <= {quo[NUM_W-2:0], fits};
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

/* hw/rtl/warmup_moving_average_core.sv */
// Warmup moving average core: boxcar mean over the last WINDOW_DEPTH samples.
// Depends on wma_pkg, wma_ram (sample ring) and wma_div (serial divider).
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one load sample per beat (bits 13:0,
//   percent times 100, upper bits zero). m_tvalid/m_tready/m_tdata carry
//   one average per input beat (bits 13:0), in order.
//   Until WINDOW_DEPTH samples have arrived the average is taken over all
//   samples seen since reset; afterwards over the last WINDOW_DEPTH.
//   The quotient is truncated.
// Timing:
//   A sample passes from accept through S_UPDATE, the serial divider (one
//   quotient bit per cycle over the running sum width) and S_OUT to the
//   output register. s_tready is high only while the sequencer is idle,
//   so a new sample is taken only once the previous average has been
//   loaded into the output register.
// Reset:
//   rst (synchronous) empties the window, clears the running sum, pointer
//   and count, and drops m_tvalid. History RAM is not cleared.
// Backpressure:
//   A finished average waits in the output register; a new sample is still
//   accepted, and its result is held until the earlier beat is taken.
module warmup_moving_average_core
  import wma_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,   // [13:0] sample, [15:14] zero
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata    // [13:0] average, [15:14] zero
);

  localparam int PTR_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_DIV,
    S_OUT
  } state_t;

  state_t              state;
  logic [SAMPLE_W-1:0] sample;
  logic [SUM_W-1:0]    running_sum;
  logic [SUM_W-1:0]    running_sum_next;
  logic [PTR_W-1:0]    write_pointer;
  logic [PTR_W-1:0]    write_pointer_next;
  logic [CNT_W-1:0]    sample_count;
  logic [CNT_W-1:0]    sample_count_next;
  logic                full;
  logic                in_beat;
  logic                out_load;
  logic [SAMPLE_W-1:0] oldest;
  logic                div_start;
  logic                div_busy;
  logic                div_done;
  logic [SUM_W-1:0]    quotient;

  assign s_tready = (state == S_IDLE);
  assign in_beat  = s_tvalid && s_tready;
  assign full     = (sample_count == CNT_W'(WINDOW_DEPTH));
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  // sample ring: oldest entry read on accept, new sample written on update
  wma_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (state == S_UPDATE),
    .waddr (write_pointer),
    .wdata (sample),
    .re    (in_beat),
    .raddr (write_pointer),
    .rdata (oldest)
  );

  // window bookkeeping for the sample being taken in
  always_comb begin
    running_sum_next = running_sum + SUM_W'(sample);
    if (full) begin
      running_sum_next = running_sum_next - SUM_W'(oldest);
    end
    sample_count_next = full ? sample_count : sample_count + CNT_W'(1);
    if (write_pointer == PTR_W'(WINDOW_DEPTH - 1)) begin
      write_pointer_next = '0;
    end else begin
      write_pointer_next = write_pointer + PTR_W'(1);
    end
  end

  assign div_start = (state == S_UPDATE);

  wma_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (running_sum_next),
    .divisor  (sample_count_next),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  // sequencer, window state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      running_sum   <= '0;
      write_pointer <= '0;
      sample_count  <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      // output register: load a finished average, or clear once taken
      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {{(TDATA_W - SAMPLE_W){1'b0}}, quotient[SAMPLE_W-1:0]};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_beat) begin
            sample <= s_tdata[SAMPLE_W-1:0];
            state  <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          running_sum   <= running_sum_next;
          sample_count  <= sample_count_next;
          write_pointer <= write_pointer_next;
          state         <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // count never passes the window depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count <= CNT_W'(WINDOW_DEPTH))
    else $error("sample count exceeds window depth");

  // while filling, the pointer tracks the count
  a_fill_pointer: assert property (@(posedge clk) disable iff (rst)
    !full |-> (write_pointer == sample_count[PTR_W-1:0]))
    else $error("write pointer out of step with sample count");

  // divider is free whenever a new sample can be taken
  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !div_busy)
    else $error("divider busy while accepting");

  // a finished quotient is always followed by the output stage
  a_done_out: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV) ##1 (state == S_OUT))
    else $error("divider result not moved to output");

endmodule
